// ----- rtl/nptm_pkg.sv -----
`default_nettype none

package nptm_pkg;

  // Flit data width seen on the port; data above it is masked off
  localparam int unsigned FLIT_WIDTH = 32;
  localparam logic [31:0] FlitMask =
      (FLIT_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << FLIT_WIDTH) - 32'd1);

  // Configuration register indexes
  localparam logic CfgRouterAddr = 1'b0;
  localparam logic CfgPortIndex  = 1'b1;

  // Record kinds
  localparam logic [1:0] KindOther    = 2'd0;
  localparam logic [1:0] KindTask     = 2'd1;
  localparam logic [1:0] KindConsumer = 2'd2;

  // Service codes
  localparam logic [31:0] SvcTaskA = 32'h40;
  localparam logic [31:0] SvcTaskB = 32'h70;
  localparam logic [31:0] SvcTaskC = 32'h23;
  localparam logic [31:0] SvcConsA = 32'h00;
  localparam logic [31:0] SvcConsB = 32'h01;
  localparam logic [31:0] SvcConsC = 32'h31;

  localparam logic [31:0] TargetMask = 32'h0000_FFFF;

  // Packet parser phases
  typedef enum logic [5:0] {
    PhHeader   = 6'b000001,
    PhSize     = 6'b000010,
    PhService  = 6'b000100,
    PhTask     = 6'b001000,
    PhConsumer = 6'b010000,
    PhTail     = 6'b100000
  } phase_e;

  function automatic logic has_consumer(input logic [31:0] svc);
    has_consumer = (svc == SvcConsA) || (svc == SvcConsB) || (svc == SvcConsC);
  endfunction

  function automatic logic has_task(input logic [31:0] svc);
    has_task = (svc == SvcTaskA) || (svc == SvcTaskB) || (svc == SvcTaskC) ||
               has_consumer(svc);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/noc_port_traffic_monitor.sv -----
// Traffic monitor for one router port.
// Input channel (in_valid_i / in_stall_o): one transfer per clock tick, carrying
// the accepted-flit flag, the flit word and the global tick time. Ticks without
// a flit must still be sent, since busy cycles are counted per transfer.
// Output channel (out_valid_o / out_stall_i): one packet record per finished
// packet, sent on the transfer of the tail flit that leaves the payload count
// at zero.
// Configuration: write router address (index 0) and port index (index 1)
// through cfg_we_i / cfg_index_i / cfg_wdata_i while the block is idle.
// A record passes through the input register, which feeds the parser, which
// loads the result register; a receiver stall can hold it in between.
// Throughput: one transfer per cycle while no record is stalled; the parser
// state updates in a single pass between the input and result registers.
// Reset clears the parser, counters and configuration; the parser waits for a
// header. While the receiver stalls with a record pending, the input register
// holds its item and in_stall_o is raised until the record is taken.
`default_nettype none

module noc_port_traffic_monitor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        flit_accepted_i,
  input  wire logic [31:0] flit_word_i,
  input  wire logic [31:0] tick_time_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       record_kind_o,
  output logic [31:0]      header_tick_o,
  output logic [15:0]      router_id_o,
  output logic [31:0]      service_code_o,
  output logic [31:0]      payload_size_o,
  output logic [31:0]      busy_cycles_o,
  output logic [3:0]       port_code_o,
  output logic [15:0]      target_id_o,
  output logic [31:0]      task_number_o,
  output logic [31:0]      consumer_number_o
);
  import nptm_pkg::*;

  logic [15:0] router_addr_q;
  logic [2:0]  port_index_q;

  logic        s1_valid_q;
  logic        s1_flit_q;
  logic [31:0] s1_word_q;
  logic [31:0] s1_tick_q;

  phase_e      phase_q, phase_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] cyc_q, cyc_d;
  logic [15:0] target_q, target_d;
  logic [31:0] htime_q, htime_d;
  logic [31:0] size_q, size_d;
  logic [31:0] svc_q, svc_d;
  logic [31:0] task_q, task_d;
  logic [31:0] cons_q, cons_d;

  logic        advance;
  logic        emit;
  logic [1:0]  kind;
  logic [31:0] word;
  logic [31:0] rem_dec;
  logic [31:0] cyc_inc;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      router_addr_q <= '0;
      port_index_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRouterAddr: router_addr_q <= cfg_wdata_i;
        CfgPortIndex:  port_index_q  <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // Process the registered item when the result slot is free
  assign advance    = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;

  // Capture input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_flit_q <= flit_accepted_i;
      s1_word_q <= flit_word_i & FlitMask;
      s1_tick_q <= tick_time_i;
    end
  end

  assign word    = s1_word_q;
  assign rem_dec = (rem_q != 32'd0) ? rem_q - 32'd1 : rem_q;
  assign cyc_inc = cyc_q + 32'd1;
  assign kind    = has_task(svc_q) ? (has_consumer(svc_q) ? KindConsumer : KindTask)
                                   : KindOther;

  // Count and parse one item
  always_comb begin
    phase_d  = phase_q;
    rem_d    = rem_q;
    cyc_d    = cyc_q;
    target_d = target_q;
    htime_d  = htime_q;
    size_d   = size_q;
    svc_d    = svc_q;
    task_d   = task_q;
    cons_d   = cons_q;
    emit     = 1'b0;
    if (!s1_flit_q) begin
      if (cyc_q != 32'd0) cyc_d = cyc_inc;
    end else begin
      rem_d = rem_dec;
      cyc_d = cyc_inc;
      unique case (phase_q)
        PhHeader: begin
          target_d = word[15:0];
          htime_d  = s1_tick_q;
          phase_d  = PhSize;
        end
        PhSize: begin
          size_d  = word;
          rem_d   = word;
          phase_d = PhService;
        end
        PhService: begin
          svc_d   = word;
          phase_d = has_task(word) ? PhTask : PhTail;
        end
        PhTask: begin
          task_d  = word;
          phase_d = has_consumer(svc_q) ? PhConsumer : PhTail;
        end
        PhConsumer: begin
          cons_d  = word;
          phase_d = PhTail;
        end
        PhTail: begin
          if (rem_dec == 32'd0) begin
            emit    = 1'b1;
            cyc_d   = '0;
            phase_d = PhHeader;
          end
        end
        default: ;
      endcase
    end
  end

  // Advance parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      rem_q    <= '0;
      cyc_q    <= '0;
      target_q <= '0;
      htime_q  <= '0;
      size_q   <= '0;
      svc_q    <= '0;
      task_q   <= '0;
      cons_q   <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      rem_q    <= rem_d;
      cyc_q    <= cyc_d;
      target_q <= target_d;
      htime_q  <= htime_d;
      size_q   <= size_d;
      svc_q    <= svc_d;
      task_q   <= task_d;
      cons_q   <= cons_d;
    end
  end

  // Hold the record until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= emit;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      record_kind_o     <= kind;
      header_tick_o     <= htime_q;
      router_id_o       <= router_addr_q;
      service_code_o    <= svc_q;
      payload_size_o    <= size_q;
      busy_cycles_o     <= cyc_inc;
      port_code_o       <= {port_index_q, 1'b0};
      target_id_o       <= target_q;
      task_number_o     <= (kind != KindOther) ? task_q : 32'd0;
      consumer_number_o <= (kind == KindConsumer) ? cons_q : 32'd0;
    end
  end

  // A record returns the parser to waiting for a header
  a_emit_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (phase_q == PhHeader && cyc_q == 32'd0))
    else $error("parser did not restart after record");

  // A record is only cut when the payload count runs out
  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |-> (rem_q <= 32'd1 && phase_q == PhTail))
    else $error("record cut with payload remaining");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (record_kind_o != 2'd3))
    else $error("invalid record kind");

  a_cons_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_kind_o != KindConsumer) |-> (consumer_number_o == 32'd0))
    else $error("consumer id set without consumer service");

endmodule

`default_nettype wire

// ----- tb/sv/noc_port_traffic_monitor_tb.sv -----
`timescale 1ns / 100ps

module noc_port_traffic_monitor_tb;
  import nptm_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned LongHoldLen  = 300;
  localparam int unsigned DrainCycles  = 6;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] hdr_tick;
    logic [15:0] router;
    logic [31:0] service;
    logic [31:0] size;
    logic [31:0] busy;
    logic [3:0]  port;
    logic [15:0] target;
    logic [31:0] task_id;
    logic [31:0] cons_num;
  } packet_record_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        flit_accepted_i;
  logic [31:0] flit_word_i;
  logic [31:0] tick_time_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  record_kind_o;
  logic [31:0] header_tick_o;
  logic [15:0] router_id_o;
  logic [31:0] service_code_o;
  logic [31:0] payload_size_o;
  logic [31:0] busy_cycles_o;
  logic [3:0]  port_code_o;
  logic [15:0] target_id_o;
  logic [31:0] task_number_o;
  logic [31:0] consumer_number_o;

  noc_port_traffic_monitor dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .flit_accepted_i   (flit_accepted_i),
    .flit_word_i       (flit_word_i),
    .tick_time_i       (tick_time_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .record_kind_o     (record_kind_o),
    .header_tick_o     (header_tick_o),
    .router_id_o       (router_id_o),
    .service_code_o    (service_code_o),
    .payload_size_o    (payload_size_o),
    .busy_cycles_o     (busy_cycles_o),
    .port_code_o       (port_code_o),
    .target_id_o       (target_id_o),
    .task_number_o     (task_number_o),
    .consumer_number_o (consumer_number_o)
  );

  // Monitor shadow state
  phase_e      mon_phase;
  logic [31:0] payload_left;
  logic [31:0] busy_count;
  logic [15:0] target_word;
  logic [31:0] hdr_stamp;
  logic [31:0] size_word;
  logic [31:0] service_word;
  logic [31:0] task_word;
  logic [31:0] consumer_word;
  logic [15:0] router_addr;
  logic [2:0]  port_sel;

  packet_record_t expected_records[$];

  logic [31:0] tick_now;
  int unsigned items_sent;
  int unsigned mismatches;
  int unsigned cycles_run;
  bit          calm;
  bit          long_hold_pending;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles_run++;
    if (cycles_run >= CycleLimit) begin
      $display("[noc_port_traffic_monitor] ERROR");
      $finish;
    end
  end

  function automatic bit carries_consumer(input logic [31:0] svc);
    return svc == SvcConsA || svc == SvcConsB || svc == SvcConsC;
  endfunction

  function automatic bit carries_task(input logic [31:0] svc);
    return svc == SvcTaskA || svc == SvcTaskB || svc == SvcTaskC || carries_consumer(svc);
  endfunction

  // Advance the shadow monitor by one transfer; queue a record when a packet ends
  task automatic predict_tick(input logic acc, input logic [31:0] raw_word,
                              input logic [31:0] tick, output bit emitted);
    logic [31:0]    word;
    packet_record_t rec;
    word = raw_word & FlitMask;
    emitted = 1'b0;
    if (!acc) begin
      if (busy_count != 0) busy_count++;
      return;
    end
    if (payload_left != 0) payload_left--;
    busy_count++;
    case (mon_phase)
      PhHeader: begin
        target_word = word[15:0];
        hdr_stamp = tick;
        mon_phase = PhSize;
      end
      PhSize: begin
        size_word = word;
        payload_left = word;
        mon_phase = PhService;
      end
      PhService: begin
        service_word = word;
        mon_phase = carries_task(word) ? PhTask : PhTail;
      end
      PhTask: begin
        task_word = word;
        mon_phase = carries_consumer(service_word) ? PhConsumer : PhTail;
      end
      PhConsumer: begin
        consumer_word = word;
        mon_phase = PhTail;
      end
      PhTail: begin
        if (payload_left == 0) begin
          if (!carries_task(service_word)) rec.kind = KindOther;
          else if (carries_consumer(service_word)) rec.kind = KindConsumer;
          else rec.kind = KindTask;
          rec.hdr_tick    = hdr_stamp;
          rec.router      = router_addr;
          rec.service     = service_word;
          rec.size        = size_word;
          rec.busy        = busy_count;
          rec.port        = {port_sel, 1'b0};
          rec.target      = target_word;
          rec.task_id     = (rec.kind != KindOther) ? task_word : 32'd0;
          rec.cons_num    = (rec.kind == KindConsumer) ? consumer_word : 32'd0;
          expected_records.push_back(rec);
          busy_count = 32'd0;
          mon_phase = PhHeader;
          emitted = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", what, exp_val, act_val);
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) note_mismatch(what, exp_val, act_val);
  endtask

  // Check each record transfer
  always @(posedge clk_i) begin : record_checker
    packet_record_t exp_rec;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_records.size() == 0) begin
        note_mismatch("unexpected record, service", 32'd0, service_code_o);
      end else begin
        exp_rec = expected_records.pop_front();
        check_field("record_kind", 32'(exp_rec.kind), 32'(record_kind_o));
        check_field("header_tick", exp_rec.hdr_tick, header_tick_o);
        check_field("router_id", 32'(exp_rec.router), 32'(router_id_o));
        check_field("service_code", exp_rec.service, service_code_o);
        check_field("payload_size", exp_rec.size, payload_size_o);
        check_field("busy_cycles", exp_rec.busy, busy_cycles_o);
        check_field("port_code", 32'(exp_rec.port), 32'(port_code_o));
        check_field("target_id", 32'(exp_rec.target), 32'(target_id_o));
        check_field("task_number", exp_rec.task_id, task_number_o);
        check_field("consumer_number", exp_rec.cons_num, consumer_number_o);
      end
    end
  end

  // Drive receiver stalls: one long hold on request, random bursts otherwise
  always @(posedge clk_i) begin : receiver_stall
    static int unsigned hold_left  = 0;
    static int unsigned burst_left = 0;
    if (long_hold_pending) begin
      long_hold_pending = 1'b0;
      hold_left = LongHoldLen;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left--;
      out_stall_i <= 1'b1;
    end else if (rst_ni && !calm && $urandom_range(0, 99) < 8) begin
      burst_left = $urandom_range(0, 9);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Offer one tick, hold it until the transfer, then predict
  task automatic send_item(input logic acc, input logic [31:0] word, output bit emitted);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    flit_accepted_i <= acc;
    flit_word_i     <= word;
    tick_time_i     <= tick_now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_tick(acc, word, tick_now, emitted);
    items_sent++;
    if ($urandom_range(0, 99) < 3) tick_now = $urandom;
    else tick_now = tick_now + 32'd1;
  endtask

  // Send one flit, preceded by random ticks without a flit
  task automatic send_flit(input logic [31:0] word, input int unsigned noise_pct,
                           output bit emitted);
    bit unused;
    while ($urandom_range(0, 99) < noise_pct) send_item(1'b0, $urandom, unused);
    send_item(1'b1, word, emitted);
  endtask

  // Send a full packet; tail flits go out until the payload count runs out
  task automatic send_packet(input logic [31:0] hdr, input logic [31:0] svc,
                             input logic [31:0] size, input int unsigned noise_pct);
    bit done;
    send_flit(hdr, noise_pct, done);
    send_flit(size, noise_pct, done);
    send_flit(svc, noise_pct, done);
    if (carries_task(svc)) send_flit($urandom, noise_pct, done);
    if (carries_consumer(svc)) send_flit($urandom, noise_pct, done);
    do send_flit($urandom, noise_pct, done); while (!done);
  endtask

  function automatic logic [31:0] pick_service();
    case ($urandom_range(0, 11))
      0: return SvcTaskA;
      1: return SvcTaskB;
      2: return SvcTaskC;
      3: return SvcConsA;
      4: return SvcConsB;
      5: return SvcConsC;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 8);
    if (roll < 95) return $urandom_range(9, 24);
    return $urandom_range(25, 60);
  endfunction

  // Wait for every record to drain, then write both registers
  task automatic set_config(input logic [15:0] addr, input logic [2:0] port);
    in_valid_i <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgRouterAddr;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_index_i <= CfgPortIndex;
    cfg_wdata_i <= {13'd0, port};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    router_addr = addr;
    port_sel    = port;
    @(posedge clk_i);
  endtask

  task automatic test_reset_config();
    send_packet($urandom, SvcTaskB, 32'd2, 0);
  endtask

  task automatic test_directed_packets();
    bit unused;
    set_config(16'hFFFF, 3'd7);
    // ticks with no flit before a header leave the busy count idle
    send_item(1'b0, 32'hFFFF_FFFF, unused);
    tick_now = 32'hFFFF_FFFF;
    send_item(1'b1, 32'hFFFF_FFFF, unused);
    send_item(1'b1, 32'd0, unused);
    send_item(1'b0, 32'd0, unused);
    send_item(1'b1, 32'hFFFF_FFFF, unused);
    send_item(1'b1, 32'hFFFF_FFFF, unused);
    tick_now = 32'd0;
    send_packet(32'd0, SvcTaskA, 32'd0, 0);
    send_packet(32'h8000_8000, SvcConsA, 32'd7, 0);
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    for (int unsigned round = 0; round < 3; round++) begin
      case (round)
        0: set_config(16'd0, 3'd4);
        1: set_config(16'h5A5A, 3'd0);
        default: set_config(16'($urandom), 3'($urandom_range(0, 7)));
      endcase
      stop_at = items_sent + 85;
      while (items_sent < stop_at)
        send_packet($urandom, pick_service(), pick_size(), $urandom_range(0, 30));
    end
  endtask

  task automatic test_backpressure();
    set_config(16'($urandom), 3'($urandom_range(0, 7)));
    long_hold_pending = 1'b1;
    repeat (12) send_packet($urandom, pick_service(), $urandom_range(0, 3), 0);
  endtask

  task automatic test_quiet_finish();
    calm = 1'b1;
    repeat (8) send_packet($urandom, pick_service(), pick_size(), 10);
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = CfgRouterAddr;
    cfg_wdata_i       = 16'd0;
    in_valid_i        = 1'b0;
    flit_accepted_i   = 1'b0;
    flit_word_i       = 32'd0;
    tick_time_i       = 32'd0;
    out_stall_i       = 1'b0;
    mon_phase         = PhHeader;
    payload_left      = 32'd0;
    busy_count        = 32'd0;
    target_word       = 16'd0;
    hdr_stamp         = 32'd0;
    size_word         = 32'd0;
    service_word      = 32'd0;
    task_word         = 32'd0;
    consumer_word     = 32'd0;
    router_addr       = 16'd0;
    port_sel          = 3'd0;
    tick_now          = 32'd0;
    items_sent        = 0;
    mismatches        = 0;
    cycles_run        = 0;
    calm              = 1'b0;
    long_hold_pending = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_config();
    test_directed_packets();
    test_random_traffic();
    test_backpressure();
    test_quiet_finish();

    // Drain remaining records
    in_valid_i <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[noc_port_traffic_monitor] OK");
    end else begin
      $display("[noc_port_traffic_monitor] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/nptm_pkg.sv
rtl/noc_port_traffic_monitor.sv
tb/sv/noc_port_traffic_monitor_tb.sv
